[sv/sbr_pkg.sv]
`default_nettype none

package sbr_pkg;

    localparam int unsigned BandCountDefault = 32;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned BandW   = 5;
    localparam int unsigned MagW    = 24;
    localparam int unsigned CoordW  = 8;
    localparam int unsigned HeightW = 7;
    localparam int unsigned ColorW  = 16;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDatW = 4;

    localparam logic [CfgIdxW-1:0] CFG_FOCUS_GROUP = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SENSITIVITY = 1'd1;

    localparam logic [1:0] FOCUS_ALL    = 2'd0;
    localparam logic [1:0] FOCUS_BASS   = 2'd1;
    localparam logic [1:0] FOCUS_MID    = 2'd2;
    localparam logic [1:0] FOCUS_TREBLE = 2'd3;

    localparam logic [TimeW-1:0]   THROTTLE_MS  = 32'd33;
    localparam logic [12:0]        FLOOR_Q8     = 13'd2560;
    localparam logic [CoordW-1:0]  BARS_TOP     = 8'd14;
    localparam logic [CoordW-1:0]  BARS_BOTTOM  = 8'd134;
    localparam logic [HeightW-1:0] BARS_MAX_H   = 7'd120;
    localparam logic [CoordW-1:0]  BAR_W        = 8'd6;
    localparam logic [CoordW-1:0]  BAR_PITCH    = 8'd7;
    localparam logic [CoordW-1:0]  BARS_LEFT    = 8'd8;
    localparam logic [CoordW-1:0]  CLEAR_W      = 8'd240;
    localparam logic [BandW-1:0]   BASS_END     = 5'd10;
    localparam logic [BandW-1:0]   MID_END      = 5'd22;

    localparam logic [ColorW-1:0] COL_BLACK = 16'h0000;
    localparam logic [ColorW-1:0] COL_WHITE = 16'hFFFF;
    localparam logic [ColorW-1:0] COL_RED   = 16'hF800;
    localparam logic [ColorW-1:0] COL_GREEN = 16'h07E0;
    localparam logic [ColorW-1:0] COL_BLUE  = 16'h001F;

    typedef struct packed {
        logic                 visible;
        logic [CoordW-1:0]    x;
        logic [CoordW-1:0]    y;
        logic [HeightW-1:0]   height;
        logic [ColorW-1:0]    color;
    } bar_t;

endpackage

`default_nettype wire

[sv/spectrum_bar_renderer_core.sv]
`default_nettype none

// Spectrum bar renderer. Each input transfer carries one band magnitude with its band index
// and frame time; band 0 opens a frame, which is dropped when fewer than 33 ms have passed
// since a last drawn frame with nonzero time, and otherwise emits a black clear rectangle
// ahead of its bar. Each band of a drawn frame yields one bar rectangle unless its height
// works out to zero. An item is registered on input and then loaded into a two-entry
// result register, from which its rectangles leave; the single output port moves one
// rectangle per cycle while m_axis_tready is high, and the next item is loaded as the last
// rectangle of the one before leaves. tlast marks the final rectangle of each item.
// Configuration writes are always ready and must only be issued while no item is in flight.
module spectrum_bar_renderer_core #(
    parameter int unsigned BAND_COUNT = sbr_pkg::BandCountDefault
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // frame_time_ms [31:0], band_index [36:32], magnitude [60:37], zero [63:61]
    input  wire logic [63:0]                  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // rect_x [7:0], rect_y [15:8], rect_width [23:16], rect_height [30:24],
    // rect_color [46:31], zero [47]
    output logic [47:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sbr_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [sbr_pkg::CfgDatW-1:0]  cfg_data
);
    import sbr_pkg::*;

    logic [1:0]       focus_reg;
    logic [3:0]       sens_reg;
    logic [TimeW-1:0] last_time_reg;
    logic             frame_active_reg;

    logic             in_valid_reg;
    logic [TimeW-1:0] in_time_reg;
    logic [BandW-1:0] in_band_reg;
    logic [MagW-1:0]  in_mag_reg;

    logic             clr_pend_reg;
    logic             bar_pend_reg;
    bar_t             bar_reg;

    bar_t             bar_calc;
    logic             pair_free;
    logic             pair_load;
    logic             band_ok;
    logic             drop;
    logic             clr_pend_next;
    logic             bar_pend_next;

    sbr_bar_calc u_calc (
        .band        (in_band_reg),
        .magnitude   (in_mag_reg),
        .focus_group (focus_reg),
        .sensitivity (sens_reg),
        .bar         (bar_calc)
    );

    assign cfg_ready = 1'b1;

    // The result register can take a new item once at most one rectangle remains and it
    // is leaving now.
    assign pair_free = !(clr_pend_reg || bar_pend_reg)
                       || (m_axis_tready && (clr_pend_reg != bar_pend_reg));
    assign pair_load     = in_valid_reg && pair_free;
    assign s_axis_tready = !in_valid_reg || pair_load;

    assign band_ok = {1'b0, in_band_reg} < 6'(BAND_COUNT);
    assign drop    = (last_time_reg != '0) && ((in_time_reg - last_time_reg) < THROTTLE_MS);

    always_comb
    begin
        clr_pend_next = clr_pend_reg;
        bar_pend_next = bar_pend_reg;
        if (m_axis_tready)
        begin
            if (clr_pend_reg)
            begin
                clr_pend_next = 1'b0;
            end
            else
            begin
                bar_pend_next = 1'b0;
            end
        end
        if (pair_load)
        begin
            clr_pend_next = 1'b0;
            bar_pend_next = 1'b0;
            if (band_ok)
            begin
                if (in_band_reg == '0)
                begin
                    clr_pend_next = !drop;
                    bar_pend_next = !drop && bar_calc.visible;
                end
                else
                begin
                    bar_pend_next = frame_active_reg && bar_calc.visible;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg        <= FOCUS_ALL;
            sens_reg         <= 4'd5;
            last_time_reg    <= '0;
            frame_active_reg <= 1'b0;
            in_valid_reg     <= 1'b0;
            clr_pend_reg     <= 1'b0;
            bar_pend_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOCUS_GROUP: focus_reg <= cfg_data[1:0];
                    CFG_SENSITIVITY: sens_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (pair_load && band_ok && (in_band_reg == '0))
            begin
                frame_active_reg <= !drop;
                if (!drop)
                begin
                    last_time_reg <= in_time_reg;
                end
            end
            clr_pend_reg <= clr_pend_next;
            bar_pend_reg <= bar_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_time_reg <= s_axis_tdata[31:0];
            in_band_reg <= s_axis_tdata[36:32];
            in_mag_reg  <= s_axis_tdata[60:37];
        end
        if (pair_load)
        begin
            bar_reg <= bar_calc;
        end
    end

    assign m_axis_tvalid = clr_pend_reg || bar_pend_reg;
    assign m_axis_tlast  = !(clr_pend_reg && bar_pend_reg);

    always_comb
    begin
        if (clr_pend_reg)
        begin
            m_axis_tdata = {1'b0, COL_BLACK, BARS_MAX_H, CLEAR_W, BARS_TOP, CoordW'(0)};
        end
        else
        begin
            m_axis_tdata = {1'b0, bar_reg.color, bar_reg.height, BAR_W, bar_reg.y, bar_reg.x};
        end
    end

endmodule

`default_nettype wire

[sv/sbr_bar_calc.sv]
`default_nettype none

module sbr_bar_calc (
    input  wire logic [sbr_pkg::BandW-1:0] band,
    input  wire logic [sbr_pkg::MagW-1:0]  magnitude,
    input  wire logic [1:0]                focus_group,
    input  wire logic [3:0]                sensitivity,
    output sbr_pkg::bar_t                  bar
);
    import sbr_pkg::*;

    logic [MagW:0]    v;
    logic [4:0]       lead;
    logic [7:0]       frac;
    logic [12:0]      log_q8;
    logic [11:0]      diff;
    logic [17:0]      prod;
    logic [9:0]       h_raw;
    logic [HeightW-1:0] h;
    logic             in_focus;
    logic [ColorW-1:0] tint;

    assign v = {1'b0, magnitude} + (MagW+1)'(1);

    always_comb
    begin
        lead = '0;
        for (int i = 1; i <= MagW; i++)
        begin
            if (v[i])
            begin
                lead = 5'(i);
            end
        end
    end

    // The eight bits just below the leading one, zero filled from the right.
    assign frac   = 8'(({v, 8'b0}) >> lead);
    assign log_q8 = {lead, frac};
    assign diff   = (log_q8 > FLOOR_Q8) ? 12'(log_q8 - FLOOR_Q8) : 12'd0;
    assign prod   = 18'(diff) * 18'(sensitivity) * 18'd3;
    assign h_raw  = prod[17:8];
    assign h      = (h_raw > 10'(BARS_MAX_H)) ? BARS_MAX_H : h_raw[HeightW-1:0];

    always_comb
    begin
        case (focus_group)
            FOCUS_BASS:
            begin
                in_focus = band < BASS_END;
                tint     = COL_RED;
            end
            FOCUS_MID:
            begin
                in_focus = (band >= BASS_END) && (band < MID_END);
                tint     = COL_GREEN;
            end
            FOCUS_TREBLE:
            begin
                in_focus = band >= MID_END;
                tint     = COL_BLUE;
            end
            default:
            begin
                in_focus = 1'b1;
                tint     = COL_WHITE;
            end
        endcase
    end

    assign bar.visible = h != '0;
    assign bar.x       = BARS_LEFT + CoordW'(band) * BAR_PITCH;
    assign bar.y       = BARS_BOTTOM - CoordW'(h);
    assign bar.height  = h;
    assign bar.color   = in_focus ? tint : COL_WHITE;

endmodule

`default_nettype wire

[dv/tb_spectrum_bar_renderer_core.sv]
`timescale 1ns / 100ps

module tb_spectrum_bar_renderer_core;
    import sbr_pkg::*;

    localparam int unsigned Bands        = 32;
    localparam int unsigned CycleLimit   = 1000000;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned PhaseItems   = 340;

    typedef struct packed {
        logic [CoordW-1:0]  x;
        logic [CoordW-1:0]  y;
        logic [CoordW-1:0]  w;
        logic [HeightW-1:0] h;
        logic [ColorW-1:0]  color;
        logic               last;
    } rect_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDatW-1:0] cfg_data;

    rect_t       expected_rects[$];
    rect_t       want_rect;
    logic [31:0] last_drawn_ms = '0;
    logic        frame_on      = 1'b0;
    logic [1:0]  focus_sel     = FOCUS_ALL;
    logic [3:0]  gain          = 4'd5;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic [31:0] now_ms      = '0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    int unsigned rx_hold_len = 0;
    int unsigned rx_left     = 0;

    spectrum_bar_renderer_core #(
        .BAND_COUNT(Bands)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 50);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [23:0] random_mag();
        int unsigned k;
        k = $urandom_range(0, 25);
        if (k == 25)
            return 24'hFFFFFF;
        return 24'($urandom & ((32'd1 << k) - 32'd1));
    endfunction

    // log2(1 + m) in Q.8 with the fraction read linearly below the leading one.
    function automatic int unsigned log_mag_q8(input logic [23:0] m);
        logic [24:0] v;
        int unsigned pos;
        int unsigned frac;
        v   = {1'b0, m} + 25'd1;
        pos = 0;
        for (int i = 0; i < 25; i++)
            if (v[i])
                pos = i;
        if (pos >= 8)
            frac = 32'(v >> (pos - 8)) & 32'hFF;
        else
            frac = 32'(v << (8 - pos)) & 32'hFF;
        return (pos << 8) | frac;
    endfunction

    function automatic logic [HeightW-1:0] bar_height_of(input logic [23:0] m);
        int unsigned lg;
        int unsigned h;
        lg = log_mag_q8(m);
        if (lg <= FLOOR_Q8)
            return '0;
        h = ((lg - FLOOR_Q8) * gain * 3) >> 8;
        if (h > BARS_MAX_H)
            h = BARS_MAX_H;
        return HeightW'(h);
    endfunction

    function automatic logic [ColorW-1:0] bar_colour(input logic [4:0] b);
        case (focus_sel)
            FOCUS_BASS:   return (b < BASS_END) ? COL_RED : COL_WHITE;
            FOCUS_MID:    return (b >= BASS_END && b < MID_END) ? COL_GREEN : COL_WHITE;
            FOCUS_TREBLE: return (b >= MID_END) ? COL_BLUE : COL_WHITE;
            default:      return COL_WHITE;
        endcase
    endfunction

    task automatic predict_rects(input logic [31:0] t, input logic [4:0] b,
                                 input logic [23:0] m);
        rect_t clear_rect;
        rect_t bar_rect;
        bit    has_clear;
        bit    has_bar;
        logic [HeightW-1:0] h;
        has_clear = 1'b0;
        has_bar   = 1'b0;
        if (b >= Bands)
            return;
        if (b == 0)
        begin
            if (last_drawn_ms != 0 && (t - last_drawn_ms) < THROTTLE_MS)
            begin
                frame_on = 1'b0;
                return;
            end
            last_drawn_ms = t;
            frame_on      = 1'b1;
            has_clear     = 1'b1;
            clear_rect    = '{x: '0, y: BARS_TOP, w: CLEAR_W, h: BARS_MAX_H,
                              color: COL_BLACK, last: 1'b0};
        end
        if (frame_on)
        begin
            h = bar_height_of(m);
            if (h != 0)
            begin
                has_bar  = 1'b1;
                bar_rect = '{x: CoordW'(BARS_LEFT + b * BAR_PITCH),
                             y: CoordW'(BARS_BOTTOM - h), w: BAR_W, h: h,
                             color: bar_colour(b), last: 1'b1};
            end
        end
        if (has_clear)
        begin
            clear_rect.last = !has_bar;
            expected_rects.push_back(clear_rect);
        end
        if (has_bar)
            expected_rects.push_back(bar_rect);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_rects(s_axis_tdata[31:0], s_axis_tdata[36:32], s_axis_tdata[60:37]);
        if (rst_n && cfg_valid && cfg_ready)
            case (cfg_index)
                CFG_FOCUS_GROUP: focus_sel = cfg_data[1:0];
                CFG_SENSITIVITY: gain = cfg_data;
                default: ;
            endcase
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_rects.size() == 0)
            begin
                $error("unexpected rectangle transfer, rect_x %0d", m_axis_tdata[7:0]);
                error_count++;
            end
            else
            begin
                want_rect = expected_rects.pop_front();
                check_field("rect_x", want_rect.x, m_axis_tdata[7:0]);
                check_field("rect_y", want_rect.y, m_axis_tdata[15:8]);
                check_field("rect_width", want_rect.w, m_axis_tdata[23:16]);
                check_field("rect_height", want_rect.h, m_axis_tdata[30:24]);
                check_field("rect_color", want_rect.color, m_axis_tdata[46:31]);
                check_field("is_last", want_rect.last, m_axis_tlast);
            end
        end
    end

    // The receiver idles at random; a requested hold-off overrides everything else.
    always @(negedge clk)
    begin
        if (rx_hold_len != 0)
        begin
            rx_left     = rx_hold_len;
            rx_hold_len = 0;
        end
        if (rx_left == 0 && !rx_steady && $urandom_range(0, 3) == 0)
            rx_left = pick_gap();
        if (rx_left != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_band(input logic [31:0] t, input logic [4:0] b, input logic [23:0] m);
        int unsigned gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, m, b, t};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rects.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic advance_frame_time();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 2)
            now_ms += $urandom_range(0, 32);
        else if (r == 2)
            now_ms = $urandom;
        else if (r == 3)
            now_ms = '0;
        else
            now_ms += $urandom_range(33, 45);
    endtask

    // Defaults after reset: throttling, the stored-zero rule, timer wrap and the floor.
    task automatic test_throttle();
        send_band(32'h0000_1234, 5'd3, 24'hFFFFFF);
        send_band(32'd0, 5'd0, 24'h000000);
        send_band($urandom, 5'd1, 24'hFFFFFF);
        send_band(32'd10, 5'd0, 24'hFFFFFF);
        send_band(32'd20, 5'd0, 24'hFFFFFF);
        send_band(32'd55, 5'd31, 24'hFFFFFF);
        send_band(32'd43, 5'd0, 24'h0003FF);
        send_band(32'd75, 5'd0, 24'h000400);
        send_band(32'hFFFF_FFF0, 5'd0, 24'h0007FF);
        send_band(32'h0000_0011, 5'd0, 24'hFFFFFF);
        send_band(32'h0000_0031, 5'd0, 24'hFFFFFF);
        now_ms = 32'h0000_0100;
    endtask

    task automatic test_focus_tints();
        logic [1:0] groups[3];
        groups = '{FOCUS_BASS, FOCUS_MID, FOCUS_TREBLE};
        for (int g = 0; g < 3; g++)
        begin
            write_cfg(CFG_FOCUS_GROUP, {2'b00, groups[g]});
            now_ms += 40;
            send_band(now_ms, 5'd0, 24'hFFFFFF);
            send_band(32'hFFFF_FFFF, 5'd9, 24'hFFFFFF);
            send_band(32'd0, 5'd10, 24'hFFFFFF);
            send_band(32'hAAAA_5555, 5'd21, 24'hFFFFFF);
            send_band(32'h5555_AAAA, 5'd22, 24'hFFFFFF);
        end
    endtask

    task automatic test_gain_extremes();
        write_cfg(CFG_SENSITIVITY, 4'd0);
        now_ms += 40;
        send_band(now_ms, 5'd0, 24'hFFFFFF);
        send_band(now_ms, 5'd7, 24'hFFFFFF);
        write_cfg(CFG_SENSITIVITY, 4'd15);
        now_ms += 40;
        send_band(now_ms, 5'd0, 24'hFFFFFF);
        send_band(now_ms, 5'd12, 24'h000800);
    endtask

    task automatic test_output_stall();
        write_cfg(CFG_FOCUS_GROUP, {2'b00, FOCUS_ALL});
        write_cfg(CFG_SENSITIVITY, 4'd10);
        tx_steady   = 1'b1;
        rx_steady   = 1'b1;
        rx_hold_len = 200;
        now_ms += 40;
        send_band(now_ms, 5'd0, 24'hFFFFFF);
        for (int b = 1; b < Bands; b++)
            send_band($urandom, 5'(b), 24'hFFFFFF);
        drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_random_frames();
        logic [3:0]  gains[6];
        int unsigned sent;
        int unsigned kind;
        int unsigned n;
        gains    = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd5, 4'd3};
        gains[4] = 4'($urandom_range(1, 10));
        gains[5] = 4'($urandom);
        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(CFG_FOCUS_GROUP, 4'($urandom_range(0, 3)));
            write_cfg(CFG_SENSITIVITY, gains[ph]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PhaseItems)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    n = $urandom_range(1, 4);
                    repeat (n) send_band($urandom, 5'($urandom), random_mag());
                end
                else
                begin
                    advance_frame_time();
                    n = (kind == 1) ? $urandom_range(1, 31) : Bands;
                    send_band(now_ms, 5'd0, random_mag());
                    for (int b = 1; b < n; b++)
                        send_band($urandom, 5'(b), random_mag());
                end
                sent += n;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_throttle();
        test_focus_tints();
        test_gain_extremes();
        test_output_stall();
        test_random_frames();
        drain();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
